>>> sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> sv/swbs_pkg.sv
// Package: shared types and constants of the bandwidth shaper.
package swbs_pkg;
  typedef enum logic [1:0] {
    CMD_ARRIVE  = 2'd0,
    CMD_SERVICE = 2'd1,
    CMD_FLUSH   = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    EV_PASS    = 3'd0,
    EV_DROP    = 3'd1,
    EV_QUEUE   = 3'd2,
    EV_RELEASE = 3'd3,
    EV_NONE    = 3'd4
  } event_e;

  typedef enum logic [1:0] {
    REG_MAX_BW = 2'd0,
    REG_QUEUE  = 2'd1,
    REG_LIM_IN = 2'd2,
    REG_LIM_OUT = 2'd3
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ARRIVE,
    ST_EVICT_RD,
    ST_EVICT_CHK,
    ST_REL_CHK,
    ST_REL_RD,
    ST_REL_EMIT,
    ST_NONE_EMIT,
    ST_WAIT_OUT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic take_in;      // capture input item
    logic do_arrive;    // process arrival, load output
    logic win_rd;       // issue read of oldest window entry
    logic win_evict;    // retire oldest window entry
    logic fifo_rd;      // issue read of fifo head
    logic do_release;   // pop fifo, record, load output
    logic do_none;      // load nothing-released output
    logic clr_run;      // clear per-item release count
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic is_service;
    logic is_flush;
    logic is_arrive;
    logic win_empty;
    logic win_old;      // oldest entry is past the window
    logic can_release;  // release condition holds
    logic run_any;      // something released this item
    logic out_busy;     // output register holds an unsent result
  } stat_t;
endpackage

>>> sv/swbs_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
module swbs_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

>>> sv/swbs_ctrl.sv
// Controller state machine sequencing arrival, eviction and release.
module swbs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  swbs_pkg::stat_t stat_i,
  output swbs_pkg::ctrl_t ctrl_o
);
  import swbs_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_WAIT_OUT;
        end
      end
      ST_WAIT_OUT: begin
        // decode captured item
        if (stat_i.is_arrive) begin
          state_d = ST_ARRIVE;
        end else if (stat_i.is_service) begin
          state_d = ST_EVICT_RD;
        end else if (stat_i.is_flush) begin
          state_d = ST_REL_CHK;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_ARRIVE: begin
        if (!stat_i.out_busy) begin
          state_d = ST_IDLE;
        end
      end
      ST_EVICT_RD: begin
        state_d = stat_i.win_empty ? ST_REL_CHK : ST_EVICT_CHK;
      end
      ST_EVICT_CHK: begin
        state_d = stat_i.win_old ? ST_EVICT_RD : ST_REL_CHK;
      end
      ST_REL_CHK: begin
        if (stat_i.can_release) begin
          state_d = ST_REL_RD;
        end else if (stat_i.run_any) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_NONE_EMIT;
        end
      end
      ST_REL_RD: begin
        state_d = ST_REL_EMIT;
      end
      ST_REL_EMIT: begin
        if (!stat_i.out_busy) begin
          state_d = ST_REL_CHK;
        end
      end
      ST_NONE_EMIT: begin
        if (!stat_i.out_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    in_stall_o = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        ctrl_o.take_in = in_valid_i;
        ctrl_o.clr_run = 1'b1;
      end
      ST_ARRIVE:    ctrl_o.do_arrive = !stat_i.out_busy;
      ST_EVICT_RD:  ctrl_o.win_rd = 1'b1;
      ST_EVICT_CHK: ctrl_o.win_evict = stat_i.win_old;
      ST_REL_CHK:   ctrl_o.fifo_rd = stat_i.can_release;
      ST_REL_EMIT:  ctrl_o.do_release = !stat_i.out_busy;
      ST_NONE_EMIT: ctrl_o.do_none = !stat_i.out_busy;
      default: ;
    endcase
  end
endmodule

>>> sv/swbs_dp.sv
// Datapath: descriptor FIFO, window ring, counters, rate test, output register.
module swbs_dp #(
  parameter int QueueDepth  = 1024,
  parameter int WindowDepth = 256,
  parameter int WindowMs    = 35,
  parameter int MaxRelease  = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  swbs_pkg::ctrl_t ctrl_i,
  output swbs_pkg::stat_t stat_o,
  input  logic [1:0]      cmd_i,
  input  logic [31:0]     now_ms_i,
  input  logic [15:0]     packet_tag_i,
  input  logic [15:0]     packet_len_i,
  input  logic            is_inbound_i,
  input  logic [19:0]     max_bw_kb_i,
  input  logic [9:0]      queue_kb_i,
  input  logic            limit_inbound_i,
  input  logic            limit_outbound_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [2:0]      event_kind_o,
  output logic [15:0]     out_tag_o,
  output logic [15:0]     out_len_o,
  output logic            last_of_run_o,
  output logic [10:0]     backlog_count_o,
  output logic [20:0]     backlog_bytes_o
);
  import swbs_pkg::*;

  localparam int QAw = $clog2(QueueDepth);
  localparam int QCw = $clog2(QueueDepth + 1);
  localparam int WAw = $clog2(WindowDepth);
  localparam int WCw = $clog2(WindowDepth + 1);
  localparam int RCw = $clog2(MaxRelease + 1);

  // captured item
  logic [1:0]  cmd_q;
  logic [31:0] now_q;
  logic [15:0] tag_q, len_q;
  logic        inb_q;

  logic [QAw-1:0] frd_q, fwr_q;
  logic [QCw-1:0] fcnt_q;
  logic [20:0]    qbytes_q;
  logic [WAw-1:0] wrd_q, wwr_q;
  logic [WCw-1:0] wcnt_q;
  logic [31:0]    wbytes_q;
  logic [RCw-1:0] run_q;

  logic [15:0] ftag_rd, flen_rd, wlen_rd;
  logic [31:0] wtime_rd;

  logic        out_valid_q;
  logic [2:0]  kind_q;
  logic [15:0] otag_q, olen_q;
  logic        last_q;
  logic [10:0] bcnt_q;
  logic [20:0] bbytes_q;

  // rate test: window_bytes*1000/WindowMs < cap  <=>  wb*1000 < cap*WindowMs
  // (exact for integer division). The window side tracks window_bytes
  // directly; the cap product only moves with the config register.
  logic [41:0] use_w;
  logic [57:0] capw_q;
  logic        rate_ok;

  always_ff @(posedge clk_i) begin
    capw_q <= 58'({max_bw_kb_i, 10'd0}) * 58'(WindowMs);
  end
  assign use_w   = 42'(wbytes_q) * 42'd1000;
  assign rate_ok = (58'(use_w) < capw_q);

  logic is_srv, fifo_full, limited, dropq;
  assign is_srv    = (cmd_q == CMD_SERVICE);
  assign limited   = inb_q ? limit_inbound_i : limit_outbound_i;
  assign fifo_full = (fcnt_q == QCw'(QueueDepth));
  assign dropq     = (qbytes_q >= {1'b0, queue_kb_i, 10'd0}) || fifo_full;

  logic push;
  assign push = ctrl_i.do_arrive && limited && !dropq;

  assign stat_o.is_arrive  = (cmd_q == CMD_ARRIVE);
  assign stat_o.is_service = is_srv;
  assign stat_o.is_flush   = (cmd_q == CMD_FLUSH);
  assign stat_o.win_empty  = (wcnt_q == '0);
  assign stat_o.win_old    = (wtime_rd + 32'(WindowMs)) < now_q;
  assign stat_o.can_release = (fcnt_q != '0) && (run_q != RCw'(MaxRelease)) &&
      (!is_srv || ((wcnt_q != WCw'(WindowDepth)) && rate_ok));
  assign stat_o.run_any  = (run_q != '0);
  assign stat_o.out_busy = out_valid_q && out_stall_i;

  swbs_ram #(.Width(16), .Depth(QueueDepth)) u_ftag (
    .clk_i, .we_i(push), .waddr_i(fwr_q), .wdata_i(tag_q),
    .re_i(ctrl_i.fifo_rd), .raddr_i(frd_q), .rdata_o(ftag_rd));
  swbs_ram #(.Width(16), .Depth(QueueDepth)) u_flen (
    .clk_i, .we_i(push), .waddr_i(fwr_q), .wdata_i(len_q),
    .re_i(ctrl_i.fifo_rd), .raddr_i(frd_q), .rdata_o(flen_rd));

  logic wpush;
  assign wpush = ctrl_i.do_release && is_srv;

  swbs_ram #(.Width(32), .Depth(WindowDepth)) u_wtime (
    .clk_i, .we_i(wpush), .waddr_i(wwr_q), .wdata_i(now_q),
    .re_i(ctrl_i.win_rd), .raddr_i(wrd_q), .rdata_o(wtime_rd));
  swbs_ram #(.Width(16), .Depth(WindowDepth)) u_wlen (
    .clk_i, .we_i(wpush), .waddr_i(wwr_q), .wdata_i(flen_rd),
    .re_i(ctrl_i.win_rd), .raddr_i(wrd_q), .rdata_o(wlen_rd));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.take_in) begin
      cmd_q <= cmd_i;
      now_q <= now_ms_i;
      tag_q <= packet_tag_i;
      len_q <= packet_len_i;
      inb_q <= is_inbound_i;
    end
  end

  logic [QCw-1:0] fcnt_nx;
  logic [20:0]    qbytes_nx;
  always_comb begin
    fcnt_nx   = fcnt_q;
    qbytes_nx = qbytes_q;
    if (push) begin
      fcnt_nx   = fcnt_q + 1'b1;
      qbytes_nx = qbytes_q + 21'(len_q);
    end else if (ctrl_i.do_release) begin
      fcnt_nx   = fcnt_q - 1'b1;
      qbytes_nx = qbytes_q - 21'(flen_rd);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frd_q <= '0; fwr_q <= '0; fcnt_q <= '0; qbytes_q <= '0;
      wrd_q <= '0; wwr_q <= '0; wcnt_q <= '0; wbytes_q <= '0;
      run_q <= '0; out_valid_q <= 1'b0;
    end else begin
      fcnt_q   <= fcnt_nx;
      qbytes_q <= qbytes_nx;
      if (push) begin
        fwr_q <= (fwr_q == QAw'(QueueDepth - 1)) ? '0 : fwr_q + 1'b1;
      end
      if (ctrl_i.do_release) begin
        frd_q <= (frd_q == QAw'(QueueDepth - 1)) ? '0 : frd_q + 1'b1;
        run_q <= run_q + 1'b1;
      end else if (ctrl_i.clr_run) begin
        run_q <= '0;
      end
      if (ctrl_i.win_evict) begin
        wrd_q    <= (wrd_q == WAw'(WindowDepth - 1)) ? '0 : wrd_q + 1'b1;
        wcnt_q   <= wcnt_q - 1'b1;
        wbytes_q <= wbytes_q - 32'(wlen_rd);
      end else if (wpush) begin
        wwr_q    <= (wwr_q == WAw'(WindowDepth - 1)) ? '0 : wwr_q + 1'b1;
        wcnt_q   <= wcnt_q + 1'b1;
        wbytes_q <= wbytes_q + 32'(flen_rd);
      end
      if (ctrl_i.do_arrive || ctrl_i.do_release || ctrl_i.do_none) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // last flag of a release: the next release check will fail
  logic rel_last;
  assign rel_last = (fcnt_q == QCw'(1)) || (run_q == RCw'(MaxRelease - 1)) ||
      (is_srv && ((wcnt_q == WCw'(WindowDepth - 1)) ||
       (58'((42'(wbytes_q) + 42'(flen_rd)) * 42'd1000) >= capw_q)));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.do_arrive) begin
      kind_q <= !limited ? EV_PASS : (dropq ? EV_DROP : EV_QUEUE);
      otag_q <= tag_q;
      olen_q <= len_q;
      last_q <= 1'b1;
    end else if (ctrl_i.do_release) begin
      kind_q <= EV_RELEASE;
      otag_q <= ftag_rd;
      olen_q <= flen_rd;
      last_q <= rel_last;
    end else if (ctrl_i.do_none) begin
      kind_q <= EV_NONE;
      otag_q <= '0;
      olen_q <= '0;
      last_q <= 1'b1;
    end
    if (ctrl_i.do_arrive || ctrl_i.do_release || ctrl_i.do_none) begin
      bcnt_q   <= 11'(fcnt_nx);
      bbytes_q <= qbytes_nx;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_kind_o    = kind_q;
  assign out_tag_o       = otag_q;
  assign out_len_o       = olen_q;
  assign last_of_run_o   = last_q;
  assign backlog_count_o = bcnt_q;
  assign backlog_bytes_o = bbytes_q;
endmodule

>>> sv/sliding_window_bandwidth_shaper.sv
// Top level of the sliding-window bandwidth shaper.
// The shaper takes one item at a time. An arrival is decoded, then loaded;
// a service reads and checks each old window entry it retires, then checks,
// reads and emits each released packet, as the FIFO and window RAMs have
// registered reads. A finished result sits in the output register while the
// controller moves on; the input stalls until every result of the current
// item has been loaded. Release last_of_run is decided when the result is
// loaded, from the state the next release check would see.
module sliding_window_bandwidth_shaper #(
  parameter int QUEUE_DEPTH  = 1024,
  parameter int WINDOW_DEPTH = 256,
  parameter int WINDOW_MS    = 35,
  parameter int MAX_RELEASE  = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [31:0] now_ms_i,
  input  logic [15:0] packet_tag_i,
  input  logic [15:0] packet_len_i,
  input  logic        is_inbound_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  event_kind_o,
  output logic [15:0] out_tag_o,
  output logic [15:0] out_len_o,
  output logic        last_of_run_o,
  output logic [10:0] backlog_count_o,
  output logic [20:0] backlog_bytes_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import swbs_pkg::*;

  logic [19:0] max_bw_q;
  logic [9:0]  queue_kb_q;
  logic        lim_in_q, lim_out_q;
  logic        wr_en;
  reg_e        reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bw_q <= 20'd10; queue_kb_q <= 10'd100; lim_in_q <= 1'b1; lim_out_q <= 1'b1;
    end else if (wr_en && paddr[1:0] == 2'b00) begin
      case (reg_sel)
        REG_MAX_BW:  max_bw_q   <= pwdata[19:0];
        REG_QUEUE:   queue_kb_q <= pwdata[9:0];
        REG_LIM_IN:  lim_in_q   <= pwdata[0];
        REG_LIM_OUT: lim_out_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_sel)
      REG_MAX_BW:  prdata = 32'(max_bw_q);
      REG_QUEUE:   prdata = 32'(queue_kb_q);
      REG_LIM_IN:  prdata = 32'(lim_in_q);
      REG_LIM_OUT: prdata = 32'(lim_out_q);
      default: ;
    endcase
  end

  ctrl_t ctrl;
  stat_t stat;

  swbs_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .stat_i(stat), .ctrl_o(ctrl));

  swbs_dp #(.QueueDepth(QUEUE_DEPTH), .WindowDepth(WINDOW_DEPTH),
            .WindowMs(WINDOW_MS), .MaxRelease(MAX_RELEASE)) u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .stat_o(stat),
    .cmd_i, .now_ms_i, .packet_tag_i, .packet_len_i, .is_inbound_i,
    .max_bw_kb_i(max_bw_q), .queue_kb_i(queue_kb_q),
    .limit_inbound_i(lim_in_q), .limit_outbound_i(lim_out_q),
    .out_valid_o, .out_stall_i, .event_kind_o, .out_tag_o, .out_len_o,
    .last_of_run_o, .backlog_count_o, .backlog_bytes_o);
endmodule

>>> sv/swbs_checker.sv
// Port-level checker for the shaper, bound to the top level.
`include "assert_macros.svh"
module swbs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  event_kind_o,
  input logic [15:0] out_tag_o,
  input logic        last_of_run_o,
  input logic [10:0] backlog_count_o
);
  import swbs_pkg::*;

  `ASSERT_NEXT(a_in_busy, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "no stall after item")
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o, "result dropped")
  `ASSERT_IMPL(a_kind_range, clk_i, rst_ni, out_valid_o, event_kind_o <= EV_NONE, "bad event kind")
  `ASSERT_IMPL(a_none_last, clk_i, rst_ni, out_valid_o && event_kind_o == EV_NONE, last_of_run_o && out_tag_o == 16'd0, "bad empty result")
  `ASSERT_IMPL(a_backlog, clk_i, rst_ni, out_valid_o, backlog_count_o <= 11'd1024, "backlog too large")
endmodule

bind sliding_window_bandwidth_shaper swbs_checker u_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .event_kind_o, .out_tag_o, .last_of_run_o, .backlog_count_o);
